/* sv/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed");

`endif

/* sv/bta_pkg.sv */
// ----------------------------------------------------------------------------
// bta_pkg
// types, codes and constants for the balanced ternary tryte alu
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam logic [2:0] REQ_ADD = 3'd0;
  localparam logic [2:0] REQ_SUB = 3'd1;
  localparam logic [2:0] REQ_MUL = 3'd2;
  localparam logic [2:0] REQ_DIV = 3'd3;
  localparam logic [2:0] REQ_NEG = 3'd4;
  localparam logic [2:0] REQ_B2T = 3'd5;
  localparam logic [2:0] REQ_T2B = 3'd6;

  localparam logic [1:0] CLS_SENT  = 2'd0;
  localparam logic [1:0] CLS_INV   = 2'd1;
  localparam logic [1:0] CLS_VALID = 2'd2;

  localparam logic [15:0] WORD_ERR       = 16'hFFFF;
  localparam logic [15:0] WORD_VALID_MAX = 16'hF2F2;
  localparam int          WORD_LIMIT     = 29524;
  localparam int          BYTE_BIAS      = 121;
  localparam int          BYTE_SPAN      = 243;

  // encode: t = v + bias + span*122, split by a reciprocal multiply
  localparam int          ENC_OFFSET = BYTE_BIAS + BYTE_SPAN * 122;
  localparam int          ENC_SHIFT  = 24;
  localparam logic [16:0] ENC_RECIP  = 17'((2**ENC_SHIFT + BYTE_SPAN - 1) / BYTE_SPAN);

  localparam int DIV_BITS      = 15;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

  typedef struct packed {
    logic [2:0]         op;
    logic               err;
    logic               zero_tryte;
    logic signed [15:0] val;
    logic signed [15:0] rv;
    logic               neg_q;
  } ctl_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] den;
    logic [DIV_BITS-1:0] quo;
  } div_t;

endpackage

/* sv/bta_decode.sv */
// ----------------------------------------------------------------------------
// bta_decode
// registered decode of both packed operands into class and value
// ----------------------------------------------------------------------------
module bta_decode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [2:0]          req_type,
  input  logic [15:0]         operand_a,
  input  logic [15:0]         operand_b,
  input  logic signed [31:0]  binary_value,
  output logic                out_valid,
  output logic [2:0]          op,
  output logic [1:0]          cls_a,
  output logic [1:0]          cls_b,
  output logic signed [15:0]  val_a,
  output logic signed [15:0]  val_b,
  output logic signed [31:0]  bin
);
  import bta_pkg::*;

  function automatic logic [1:0] word_class(input logic [15:0] w);
    logic [1:0] c;
    if (w == WORD_ERR) c = CLS_SENT;
    else if (w > WORD_VALID_MAX) c = CLS_INV;
    else c = CLS_VALID;
    return c;
  endfunction

  function automatic logic signed [15:0] half_value(input logic [7:0] b);
    logic [7:0] m;
    m = (b >= 8'(BYTE_SPAN)) ? 8'(b - 8'(BYTE_SPAN)) : b;
    return $signed({8'd0, m}) - 16'sd121;
  endfunction

  function automatic logic signed [15:0] word_val(input logic [15:0] w);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = half_value(w[7:0]);
    hi = half_value(w[15:8]);
    return 16'(lo + hi * 16'sd243);
  endfunction

  logic [1:0] ca, cb;

  assign ca = word_class(operand_a);
  assign cb = word_class(operand_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    op    <= req_type;
    cls_a <= ca;
    cls_b <= cb;
    val_a <= (ca == CLS_VALID) ? word_val(operand_a) : 16'sd0;
    val_b <= (cb == CLS_VALID) ? word_val(operand_b) : 16'sd0;
    bin   <= binary_value;
  end

endmodule

/* sv/bta_div_stage.sv */
// ----------------------------------------------------------------------------
// bta_div_stage
// one registered slice of the restoring divider, DIV_PER_STAGE (three) quotient bits each
// ----------------------------------------------------------------------------
module bta_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  bta_pkg::div_t  din,
  input  bta_pkg::ctl_t  cin,
  output logic           out_valid,
  output bta_pkg::div_t  dout,
  output bta_pkg::ctl_t  cout
);
  import bta_pkg::*;

  div_t  nxt;

  always_comb begin
    logic [DIV_BITS:0]   t;
    logic [DIV_BITS-1:0] r;
    logic [DIV_BITS-1:0] n;
    logic [DIV_BITS-1:0] q;
    r = din.rem;
    n = din.num;
    q = din.quo;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      t = {r, n[DIV_BITS-1]};
      n = {n[DIV_BITS-2:0], 1'b0};
      if (t >= {1'b0, din.den}) begin
        r = DIV_BITS'(t - {1'b0, din.den});
        q = {q[DIV_BITS-2:0], 1'b1};
      end else begin
        r = t[DIV_BITS-1:0];
        q = {q[DIV_BITS-2:0], 1'b0};
      end
    end
    nxt.rem = r;
    nxt.num = n;
    nxt.den = din.den;
    nxt.quo = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    dout <= nxt;
    cout <= cin;
  end

endmodule

/* sv/bta_encode.sv */
// ----------------------------------------------------------------------------
// bta_encode
// two-stage packing of a binary value into the canonical tryte
// ----------------------------------------------------------------------------
module bta_encode (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  bta_pkg::ctl_t       cin,
  output logic                done,
  output logic [15:0]         result_tryte,
  output logic signed [15:0]  result_value,
  output logic                error_flag
);
  import bta_pkg::*;

  logic        e1_valid;
  ctl_t        e1_ctl;
  logic [15:0] e1_t;
  logic [32:0] e1_prod;
  logic [15:0] t_next;
  logic [7:0]  q;
  logic [7:0]  lo;

  assign t_next = 16'($signed({cin.val[15], cin.val}) + 17'(ENC_OFFSET));
  assign q      = e1_prod[ENC_SHIFT +: 8];
  assign lo     = 8'(e1_t - 16'(q * 16'(BYTE_SPAN)));

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      e1_valid <= in_valid;
      done     <= e1_valid;
    end
    e1_ctl  <= cin;
    e1_t    <= t_next;
    e1_prod <= {17'd0, t_next} * {16'd0, ENC_RECIP};
    if (e1_ctl.err) begin
      result_tryte <= WORD_ERR;
    end else if (e1_ctl.zero_tryte) begin
      result_tryte <= 16'd0;
    end else begin
      result_tryte <= {8'(q - 8'd1), lo};
    end
    result_value <= e1_ctl.rv;
    error_flag   <= e1_ctl.err;
  end

endmodule

/* sv/balanced_ternary_tryte_alu_core.sv */
// ----------------------------------------------------------------------------
// balanced_ternary_tryte_alu_core
// done strobes once the request has passed the decode and operand registers,
// the five-slice divider pipeline and the two-stage encoder
// throughput: one request per cycle, busy is always low
// synchronous active-high reset clears all pipeline valid bits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module balanced_ternary_tryte_alu_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          req_type,
  input  logic [15:0]         operand_a,
  input  logic [15:0]         operand_b,
  input  logic signed [31:0]  binary_value,
  output logic                done,
  output logic [15:0]         result_tryte,
  output logic signed [15:0]  result_value,
  output logic                error_flag
);
  import bta_pkg::*;

  logic               s1_valid;
  logic [2:0]         s1_op;
  logic [1:0]         s1_ca, s1_cb;
  logic signed [15:0] s1_va, s1_vb;
  logic signed [31:0] s1_bin;

  logic               s2_valid;
  logic [2:0]         s2_op;
  logic               s2_err;
  logic signed [16:0] s2_sum;
  logic signed [31:0] s2_prod;
  logic signed [15:0] s2_va;
  logic signed [31:0] s2_bin;
  logic [DIV_BITS-1:0] s2_mag_a, s2_mag_b;
  logic               s2_neg_q;

  logic signed [32:0] x;
  logic               range_err;
  logic               need_range;
  ctl_t               ctl0;
  div_t               div0;

  logic               dv_valid [DIV_STAGES+1];
  div_t               dv_data  [DIV_STAGES+1];
  ctl_t               dv_ctl   [DIV_STAGES+1];

  ctl_t               enc_ctl;
  logic [DIV_BITS-1:0] quo;
  logic               s1_err;

  assign busy = 1'b0;

  bta_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (start),
    .req_type     (req_type),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .binary_value (binary_value),
    .out_valid    (s1_valid),
    .op           (s1_op),
    .cls_a        (s1_ca),
    .cls_b        (s1_cb),
    .val_a        (s1_va),
    .val_b        (s1_vb),
    .bin          (s1_bin)
  );

  always_comb begin
    unique case (s1_op)
      REQ_ADD, REQ_SUB: s1_err = !(s1_ca == CLS_VALID && s1_cb == CLS_VALID);
      REQ_MUL:          s1_err = (s1_ca == CLS_SENT) || (s1_cb == CLS_SENT);
      REQ_DIV:          s1_err = (s1_ca == CLS_SENT) || (s1_cb == CLS_SENT) ||
                                 (s1_vb == 16'sd0);
      REQ_NEG:          s1_err = (s1_ca != CLS_VALID);
      REQ_B2T:          s1_err = 1'b0;
      REQ_T2B:          s1_err = (s1_ca == CLS_SENT);
      default:          s1_err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op    <= s1_op;
    s2_err   <= s1_err;
    s2_sum   <= (s1_op == REQ_SUB) ? 17'(s1_va) - 17'(s1_vb) : 17'(s1_va) + 17'(s1_vb);
    s2_prod  <= s1_va * s1_vb;
    s2_va    <= s1_va;
    s2_bin   <= s1_bin;
    s2_mag_a <= DIV_BITS'(s1_va[15] ? -s1_va : s1_va);
    s2_mag_b <= DIV_BITS'(s1_vb[15] ? -s1_vb : s1_vb);
    s2_neg_q <= s1_va[15] ^ s1_vb[15];
  end

  always_comb begin
    need_range = 1'b1;
    case (s2_op)
      REQ_ADD, REQ_SUB: x = 33'(s2_sum);
      REQ_MUL:          x = 33'(s2_prod);
      REQ_NEG:          x = -33'(s2_va);
      REQ_B2T:          x = 33'(s2_bin);
      default: begin
        x          = 33'sd0;
        need_range = 1'b0;
      end
    endcase
    range_err = (x > 33'sd29524) || (x < -33'sd29524);
    ctl0.op         = s2_op;
    ctl0.err        = s2_err || (need_range && range_err);
    ctl0.zero_tryte = (s2_op == REQ_T2B);
    ctl0.val        = x[15:0];
    ctl0.rv         = (s2_op == REQ_T2B) ? s2_va : 16'sd0;
    ctl0.neg_q      = s2_neg_q;
    div0.rem        = '0;
    div0.num        = s2_mag_a;
    div0.den        = s2_mag_b;
    div0.quo        = '0;
  end

  assign dv_valid[0] = s2_valid;
  assign dv_data[0]  = div0;
  assign dv_ctl[0]   = ctl0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    bta_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv_valid[g]),
      .din       (dv_data[g]),
      .cin       (dv_ctl[g]),
      .out_valid (dv_valid[g+1]),
      .dout      (dv_data[g+1]),
      .cout      (dv_ctl[g+1])
    );
  end

  assign quo = dv_data[DIV_STAGES].quo;

  always_comb begin
    enc_ctl = dv_ctl[DIV_STAGES];
    if (enc_ctl.op == REQ_DIV) begin
      enc_ctl.val = enc_ctl.neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    end
  end

  bta_encode u_encode (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dv_valid[DIV_STAGES]),
    .cin          (enc_ctl),
    .done         (done),
    .result_tryte (result_tryte),
    .result_value (result_value),
    .error_flag   (error_flag)
  );

  `ASSERT_IMPLY(a_done_follows_start, done, $past(start, 9))
  `ASSERT_IMPLY(a_err_sentinel, done && error_flag, result_tryte == WORD_ERR)
  `ASSERT_IMPLY(a_ok_not_sentinel, done && !error_flag, result_tryte != WORD_ERR)
  `ASSERT_IMPLY(a_value_only_ok, done && result_value != 16'sd0, !error_flag)

endmodule
